// ===== rtl/core/demg_pkg.sv =====
// Shared constants, command codes and lane control type for the dual EMG envelope block.
package demg_pkg;

  localparam int COUNT_LIMIT = 65536;
  localparam int CNT_W   = $clog2(COUNT_LIMIT + 1);
  localparam int SMP_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int ENV_W   = 32;
  localparam int Q_W     = 20;
  localparam int TOT_W   = Q_W + CNT_W - 1;
  localparam int SQ_W    = 2 * Q_W + CNT_W - 1;
  localparam int DIVN_W  = SQ_W + 1;
  localparam int DCNT_W  = $clog2(DIVN_W);
  localparam int SQ_PAIRS = (DIVN_W + 1) / 2;
  localparam int SRAD_W  = 2 * SQ_PAIRS;
  localparam int SCNT_W  = $clog2(SQ_PAIRS);
  localparam int CMD_W   = 3;
  localparam int IN_W    = 2 * SMP_W + 2 * Q_W;
  localparam int OUT_W   = 2 * ENV_W + 6 * Q_W;
  localparam int ADDR_W  = 3;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(13107);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_CLR_BASE = 3'd1,
    CMD_ADD_BASE = 3'd2,
    CMD_CLR_RND  = 3'd3,
    CMD_ADD_RND  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              base_add;
    logic              round_add;
    logic [CNT_W-1:0]  base_count;
    logic [CNT_W-1:0]  round_count;
    logic [GAIN_W-1:0] gain;
  } lane_ctl_t;

endpackage

// ===== rtl/core/dual_emg_envelope_stats.sv =====
// Top level: stream and register ports, shared counts, two channel lanes and result merge.
// The time from input transfer to result is set by the lane divider (up to three
// divisions per item) and the 29-step square root.
// Throughput: one item at a time; the next input is taken once the result is registered.
// The output register lets a new item start while a result waits to be taken.
// Synchronous active-high reset clears envelopes, statistics and counts; gain resets to 13107.
module dual_emg_envelope_stats (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // sample_a, sample_b, round_value_a, round_value_b
  input  logic [demg_pkg::IN_W-1:0]     s_tdata,
  // cmd
  input  logic [demg_pkg::CMD_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // envelope_a, envelope_b, baseline_mean_a, baseline_sigma_a, baseline_mean_b,
  // baseline_sigma_b, round_average_a, round_average_b
  output logic [demg_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [demg_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import demg_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t            state;
  logic [GAIN_W-1:0] gain;
  logic [CNT_W-1:0]  base_count;
  logic [CNT_W-1:0]  round_count;
  lane_ctl_t         ctl;
  logic [IN_W-1:0]   item;
  logic              start;
  logic              seen_a;
  logic              seen_b;
  logic              accept;
  logic              base_ok;
  logic              round_ok;
  logic              all_done;
  logic              out_load;

  logic [ENV_W-1:0] env_a, env_b;
  logic [Q_W-1:0]   mean_a, mean_b, sig_a, sig_b, avg_a, avg_b;
  logic             done_a, done_b;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {{(32-GAIN_W){1'b0}}, gain} : '0;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign base_ok  = (base_count < CNT_W'(COUNT_LIMIT));
  assign round_ok = (round_count < CNT_W'(COUNT_LIMIT));
  assign all_done = (seen_a || done_a) && (seen_b || done_b);
  assign out_load = (state == S_RUN) && all_done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      gain <= pwdata[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start       <= 1'b0;
      seen_a      <= 1'b0;
      seen_b      <= 1'b0;
      m_tvalid    <= 1'b0;
      base_count  <= '0;
      round_count <= '0;
    end else begin
      start <= accept;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item          <= s_tdata;
            ctl.cmd       <= s_tuser;
            ctl.gain      <= gain;
            ctl.base_add  <= (s_tuser == CMD_ADD_BASE) && base_ok;
            ctl.round_add <= (s_tuser == CMD_ADD_RND) && round_ok;
            ctl.base_count  <= (s_tuser == CMD_CLR_BASE) ? '0 :
                               ((s_tuser == CMD_ADD_BASE) && base_ok) ? base_count + 1'b1 :
                               base_count;
            ctl.round_count <= (s_tuser == CMD_CLR_RND) ? '0 :
                               ((s_tuser == CMD_ADD_RND) && round_ok) ? round_count + 1'b1 :
                               round_count;
            if (s_tuser == CMD_CLR_BASE) base_count <= '0;
            else if (s_tuser == CMD_ADD_BASE && base_ok) base_count <= base_count + 1'b1;
            if (s_tuser == CMD_CLR_RND) round_count <= '0;
            else if (s_tuser == CMD_ADD_RND && round_ok) round_count <= round_count + 1'b1;
            seen_a <= 1'b0;
            seen_b <= 1'b0;
            state  <= S_RUN;
          end
        end
        S_RUN: begin
          if (done_a) seen_a <= 1'b1;
          if (done_b) seen_b <= 1'b1;
          if (out_load) begin
            m_tdata  <= {avg_b, avg_a, sig_b, mean_b, sig_a, mean_a, env_b, env_a};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  demg_lane u_lane_a (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .ctl        (ctl),
    .sample     (item[SMP_W-1:0]),
    .round_value(item[2*SMP_W +: Q_W]),
    .envelope   (env_a),
    .mean       (mean_a),
    .sigma      (sig_a),
    .average    (avg_a),
    .done       (done_a)
  );

  demg_lane u_lane_b (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .ctl        (ctl),
    .sample     (item[SMP_W +: SMP_W]),
    .round_value(item[2*SMP_W+Q_W +: Q_W]),
    .envelope   (env_b),
    .mean       (mean_b),
    .sigma      (sig_b),
    .average    (avg_b),
    .done       (done_b)
  );

  assert property (@(posedge clk) disable iff (rst) accept |=> start)
    else $error("lanes not started after input transfer");
  assert property (@(posedge clk) disable iff (rst)
      base_count <= CNT_W'(COUNT_LIMIT) && round_count <= CNT_W'(COUNT_LIMIT))
    else $error("count beyond limit");
  assert property (@(posedge clk) disable iff (rst) (done_a || done_b) |-> state == S_RUN)
    else $error("lane result with no item in flight");
  assert property (@(posedge clk) disable iff (rst) start |-> ctl.cmd == $past(s_tuser))
    else $error("lane command differs from transferred item");

endmodule

// ===== rtl/core/demg_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module demg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [demg_pkg::DIVN_W-1:0]   num,
  input  logic [demg_pkg::CNT_W-1:0]    den,
  output logic [demg_pkg::DIVN_W-1:0]   quot,
  output logic                          done
);
  import demg_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic              qbit;

  assign trial = {rem, quot[DIVN_W-1]};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == '0);
      if (start) begin
        quot <= num;
        rem  <= '0;
        cnt  <= DCNT_W'(DIVN_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= qbit ? CNT_W'(trial - {1'b0, den}) : CNT_W'(trial);
        quot <= {quot[DIVN_W-2:0], qbit};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/demg_lane.sv =====
// One channel: envelope follower, baseline and round totals, mean/sigma/average sequencer.
module demg_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  demg_pkg::lane_ctl_t         ctl,
  input  logic [demg_pkg::SMP_W-1:0]  sample,
  input  logic [demg_pkg::Q_W-1:0]    round_value,
  output logic [demg_pkg::ENV_W-1:0]  envelope,
  output logic [demg_pkg::Q_W-1:0]    mean,
  output logic [demg_pkg::Q_W-1:0]    sigma,
  output logic [demg_pkg::Q_W-1:0]    average,
  output logic                        done
);
  import demg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_MEAN_GO, S_MEAN_WAIT, S_MSQ_GO, S_MSQ_WAIT,
    S_SQ_PREP, S_SQRT, S_SQ_FIN, S_RND_GO, S_RND_WAIT, S_DONE
  } state_t;

  state_t state;

  logic [TOT_W-1:0]  base_total;
  logic [SQ_W-1:0]   base_sq_total;
  logic [TOT_W-1:0]  round_total;
  logic [2*ENV_W-15:0] prod;
  logic              up;
  logic [DIVN_W-1:0] msq;
  logic [2*Q_W-1:0]  m2;
  logic [SRAD_W-1:0] srad;
  logic [SQ_PAIRS-1:0] root;
  logic [SQ_PAIRS+1:0] srem;
  logic [SCNT_W-1:0] scnt;

  logic [SMP_W:0]    rect;
  logic [ENV_W:0]    target;
  logic [ENV_W:0]    diff;
  logic [ENV_W:0]    step;
  logic [ENV_W:0]    q_sum;
  logic [Q_W-1:0]    q;
  logic [2*Q_W-1:0]  q_sq;
  logic [SQ_PAIRS+3:0] srem_sh;
  logic [SQ_PAIRS+1:0] strial;

  logic              div_start;
  logic [DIVN_W-1:0] div_num;
  logic [DIVN_W-1:0] div_quot;
  logic              div_done;

  assign rect   = sample[SMP_W-1] ? ((SMP_W+1)'(1) << SMP_W) - {1'b0, sample}
                                  : {1'b0, sample};
  assign target = {rect, 16'b0};
  assign diff   = (target >= {1'b0, envelope}) ? target - {1'b0, envelope}
                                               : {1'b0, envelope} - target;
  assign step   = (ENV_W+1)'((prod + 49'h8000) >> 16);
  assign q_sum  = {1'b0, envelope} + (ENV_W+1)'(2048);
  assign q      = Q_W'(q_sum >> 12);
  assign q_sq   = (2*Q_W)'(q) * (2*Q_W)'(q);
  assign srem_sh = {srem, srad[SRAD_W-1 -: 2]};
  assign strial  = {root, 2'b01};

  demg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  ((state == S_RND_GO || state == S_RND_WAIT) ? ctl.round_count : ctl.base_count),
    .quot (div_quot),
    .done (div_done)
  );

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    unique case (state)
      S_MEAN_GO: begin
        div_start = (ctl.base_count != '0);
        div_num   = DIVN_W'(base_total) + DIVN_W'(ctl.base_count >> 1);
      end
      S_MSQ_GO: begin
        div_start = (ctl.base_count > CNT_W'(1));
        div_num   = DIVN_W'(base_sq_total) + DIVN_W'(ctl.base_count >> 1);
      end
      S_RND_GO: begin
        div_start = (ctl.round_count != '0);
        div_num   = DIVN_W'(round_total) + DIVN_W'(ctl.round_count >> 1);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      envelope      <= '0;
      base_total    <= '0;
      base_sq_total <= '0;
      round_total   <= '0;
      mean          <= '0;
      sigma         <= '0;
      average       <= '0;
    end else begin
      done <= (state == S_DONE);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            prod  <= (2*ENV_W-14)'(diff) * (2*ENV_W-14)'(ctl.gain);
            up    <= (target >= {1'b0, envelope});
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (ctl.cmd == CMD_PUSH) begin
            envelope <= up ? ENV_W'({1'b0, envelope} + step)
                           : ENV_W'({1'b0, envelope} - step);
          end
          if (ctl.cmd == CMD_CLR_BASE) begin
            base_total    <= '0;
            base_sq_total <= '0;
          end
          if (ctl.base_add) begin
            base_total    <= base_total + TOT_W'(q);
            base_sq_total <= base_sq_total + SQ_W'(q_sq);
          end
          if (ctl.cmd == CMD_CLR_RND) round_total <= '0;
          if (ctl.round_add) round_total <= round_total + TOT_W'(round_value);
          state <= S_MEAN_GO;
        end
        S_MEAN_GO: begin
          if (ctl.base_count == '0) begin
            mean  <= '0;
            state <= S_MSQ_GO;
          end else begin
            state <= S_MEAN_WAIT;
          end
        end
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean  <= Q_W'(div_quot);
            state <= S_MSQ_GO;
          end
        end
        S_MSQ_GO: begin
          if (ctl.base_count <= CNT_W'(1)) begin
            sigma <= '0;
            state <= S_RND_GO;
          end else begin
            state <= S_MSQ_WAIT;
          end
        end
        S_MSQ_WAIT: begin
          if (div_done) begin
            msq   <= div_quot;
            m2    <= mean * mean;
            state <= S_SQ_PREP;
          end
        end
        S_SQ_PREP: begin
          if (msq <= DIVN_W'(m2)) begin
            sigma <= '0;
            state <= S_RND_GO;
          end else begin
            srad  <= SRAD_W'(msq - DIVN_W'(m2));
            root  <= '0;
            srem  <= '0;
            scnt  <= SCNT_W'(SQ_PAIRS - 1);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (srem_sh >= (SQ_PAIRS+4)'(strial)) begin
            srem <= (SQ_PAIRS+2)'(srem_sh - (SQ_PAIRS+4)'(strial));
            root <= {root[SQ_PAIRS-2:0], 1'b1};
          end else begin
            srem <= (SQ_PAIRS+2)'(srem_sh);
            root <= {root[SQ_PAIRS-2:0], 1'b0};
          end
          srad <= srad << 2;
          scnt <= scnt - 1'b1;
          if (scnt == '0) state <= S_SQ_FIN;
        end
        S_SQ_FIN: begin
          sigma <= (srem > (SQ_PAIRS+2)'(root)) ? Q_W'(root + 1'b1) : Q_W'(root);
          state <= S_RND_GO;
        end
        S_RND_GO: begin
          if (ctl.round_count == '0) begin
            average <= '0;
            state   <= S_DONE;
          end else begin
            state <= S_RND_WAIT;
          end
        end
        S_RND_WAIT: begin
          if (div_done) begin
            average <= Q_W'(div_quot);
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) envelope <= 32'h8000_0000)
    else $error("envelope above 2^31");
  assert property (@(posedge clk) disable iff (rst) div_done |-> (state == S_MEAN_WAIT ||
      state == S_MSQ_WAIT || state == S_RND_WAIT))
    else $error("divider finished outside a wait state");
  assert property (@(posedge clk) disable iff (rst) done |-> state == S_IDLE)
    else $error("lane done while not idle");

endmodule
